// ===== rtl/fpcc_pkg.sv =====
// Shared types and constants for the fire pixel color classifier.
package fpcc_pkg;

    localparam int CordicSteps = 16;
    localparam int CordicWidth = 26;
    localparam int AccWidth    = 25;
    localparam int SatQuoWidth = 18;
    localparam int SatDivWidth = 10;

    typedef enum logic [1:0] {
        REG_RED_THRESHOLD  = 2'd0,
        REG_HUE_LIMIT      = 2'd1,
        REG_INTENSITY_THR  = 2'd2,
        REG_SAT_SLOPE      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  red_threshold;
        logic [8:0]  hue_limit_degrees;
        logic [9:0]  intensity_sum_threshold;
        logic [15:0] saturation_slope;
    } cfg_t;

    typedef struct packed {
        logic [7:0] pixel_blue;
        logic [7:0] pixel_green;
        logic [7:0] pixel_red;
        logic       moving;
    } pix_in_t;

    typedef struct packed {
        logic        rgb_fire;
        logic        hsi_fire;
        logic        hue_defined;
        logic [14:0] hue;
        logic [16:0] saturation;
        logic [9:0]  intensity_sum;
    } pix_out_t;

    function automatic logic signed [AccWidth-1:0] atan_entry(input logic [3:0] idx);
        logic signed [AccWidth-1:0] v;
        unique case (idx)
            4'd0:    v = 25'sd2949120;
            4'd1:    v = 25'sd1740967;
            4'd2:    v = 25'sd919879;
            4'd3:    v = 25'sd466945;
            4'd4:    v = 25'sd234379;
            4'd5:    v = 25'sd117304;
            4'd6:    v = 25'sd58666;
            4'd7:    v = 25'sd29335;
            4'd8:    v = 25'sd14668;
            4'd9:    v = 25'sd7334;
            4'd10:   v = 25'sd3667;
            4'd11:   v = 25'sd1833;
            4'd12:   v = 25'sd917;
            4'd13:   v = 25'sd458;
            4'd14:   v = 25'sd229;
            default: v = 25'sd115;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/fpcc_stream_if.sv =====
// Valid/ready stream interface carrying a packed payload.
interface fpcc_stream_if #(
    parameter int Width = 8
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fpcc_pipe.sv =====
// Classifier datapath: front end, CORDIC and divider stages, decision stage.
module fpcc_pipe (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  fpcc_pkg::pix_in_t      in_pix,
    input  fpcc_pkg::cfg_t         cfg,
    output logic                   out_valid,
    output fpcc_pkg::pix_out_t     out_pix
);
    localparam int N  = fpcc_pkg::CordicSteps;
    localparam int W  = fpcc_pkg::CordicWidth;
    localparam int AW = fpcc_pkg::AccWidth;
    localparam int DW = fpcc_pkg::SatDivWidth;

    // stage 0: front end
    logic                 v0_reg;
    logic                 rgb0_reg, def0_reg, sw0_reg, spec0_reg;
    logic [14:0]          spec_th0_reg;
    logic signed [W-1:0]  x0_reg, y0_reg;
    logic signed [AW-1:0] a0_reg;
    logic [7:0]           r0_reg;
    logic [9:0]           sum0_reg;
    logic [DW-1:0]        num0_reg;

    logic [7:0]           b_in, g_in, r_in, mn;
    logic [9:0]           sum_c;
    logic signed [W-1:0]  x_c, y_c, xr_c, yr_c;
    logic signed [AW-1:0] a_c;
    logic [8:0]           dgb;

    always_comb
    begin
        b_in  = in_pix.pixel_blue;
        g_in  = in_pix.pixel_green;
        r_in  = in_pix.pixel_red;
        sum_c = 10'(r_in) + 10'(g_in) + 10'(b_in);
        mn    = (r_in < g_in) ? r_in : g_in;
        if (b_in < mn)
            mn = b_in;
        dgb   = (g_in >= b_in) ? 9'(g_in - b_in) : 9'(b_in - g_in);
        x_c   = W'((W'(signed'({2'b0, r_in})) * 2 - W'(signed'({2'b0, g_in}))
                 - W'(signed'({2'b0, b_in}))) * 16384);
        y_c   = W'(signed'({1'b0, dgb}) * 28378);
        if (x_c < 0)
        begin
            xr_c = y_c;
            yr_c = -x_c;
            a_c  = AW'(90 * 65536);
        end
        else
        begin
            xr_c = x_c;
            yr_c = y_c;
            a_c  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rgb0_reg <= in_pix.moving && (r_in > cfg.red_threshold) && (r_in >= g_in)
                        && (g_in > b_in);
            def0_reg <= !((r_in == g_in) && (g_in == b_in));
            sw0_reg  <= b_in > g_in;
            spec0_reg <= (y_c == 0) || (x_c == 0);
            spec_th0_reg <= (y_c == 0) ? ((x_c > 0) ? 15'd0 : 15'd11520) : 15'd5760;
            x0_reg   <= xr_c;
            y0_reg   <= yr_c;
            a0_reg   <= a_c;
            r0_reg   <= r_in;
            sum0_reg <= sum_c;
            num0_reg <= DW'(sum_c - 10'(mn) * 10'd3);
        end
    end

    // stages 1..N: one CORDIC step and one quotient bit per stage
    logic                 v_reg    [N+1];
    logic                 rgb_reg  [N+1];
    logic                 def_reg  [N+1];
    logic                 sw_reg   [N+1];
    logic                 spec_reg [N+1];
    logic [14:0]          sth_reg  [N+1];
    logic signed [W-1:0]  x_reg    [N+1];
    logic signed [W-1:0]  y_reg    [N+1];
    logic signed [AW-1:0] a_reg    [N+1];
    logic [7:0]           r_reg    [N+1];
    logic [9:0]           sum_reg  [N+1];

    // Saturation = floor((num*65536 + floor(sum/2)) / sum), restoring divide.
    // Dividend D = num*65536 + sum/2, 27 bits; quotient < 2^17.
    // Each stage retires one quotient bit.
    logic [26:0]          dvd_reg  [N+1];
    logic [16:0]          qt_reg   [N+1];
    logic [9:0]           dvs_reg  [N+1];

    always_comb
    begin
        v_reg[0]    = v0_reg;
        rgb_reg[0]  = rgb0_reg;
        def_reg[0]  = def0_reg;
        sw_reg[0]   = sw0_reg;
        spec_reg[0] = spec0_reg;
        sth_reg[0]  = spec_th0_reg;
        x_reg[0]    = x0_reg;
        y_reg[0]    = y0_reg;
        a_reg[0]    = a0_reg;
        r_reg[0]    = r0_reg;
        sum_reg[0]  = sum0_reg;
        dvd_reg[0]  = {1'b0, num0_reg, 16'd0} + 27'(sum0_reg >> 1);
        dvs_reg[0]  = sum0_reg;
        qt_reg[0]   = '0;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic signed [W-1:0] xs, ys, xn, yn;
        logic signed [AW-1:0] an;
        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (y_reg[i] >= 0)
            begin
                xn = x_reg[i] + ys;
                yn = y_reg[i] - xs;
                an = a_reg[i] + fpcc_pkg::atan_entry(4'(i));
            end
            else
            begin
                xn = x_reg[i] - ys;
                yn = y_reg[i] + xs;
                an = a_reg[i] - fpcc_pkg::atan_entry(4'(i));
            end
        end

        // quotient bit 16-i
        logic [26:0] trial;
        logic        take;
        always_comb
        begin
            trial = 27'(dvs_reg[i]) << (16 - i);
            take  = dvd_reg[i] >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (adv)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rgb_reg[i+1]  <= rgb_reg[i];
                def_reg[i+1]  <= def_reg[i];
                sw_reg[i+1]   <= sw_reg[i];
                spec_reg[i+1] <= spec_reg[i];
                sth_reg[i+1]  <= sth_reg[i];
                x_reg[i+1]    <= xn;
                y_reg[i+1]    <= yn;
                a_reg[i+1]    <= an;
                r_reg[i+1]    <= r_reg[i];
                sum_reg[i+1]  <= sum_reg[i];
                dvd_reg[i+1]  <= take ? dvd_reg[i] - trial : dvd_reg[i];
                qt_reg[i+1]   <= qt_reg[i] | (take ? (17'd1 << (16 - i)) : 17'd0);
                dvs_reg[i+1]  <= dvs_reg[i];
            end
        end
    end

    // last quotient bit and hue rounding
    logic        v17_reg, rgb17_reg, def17_reg;
    logic [14:0] hue17_reg;
    logic [16:0] sat17_reg;
    logic [7:0]  r17_reg;
    logic [9:0]  sum17_reg;

    logic [26:0]          lt;
    logic [16:0]          qf;
    logic signed [AW-1:0] ar;
    logic [14:0]          th, hue_c;

    always_comb
    begin
        lt = 27'(dvs_reg[N]);
        qf = qt_reg[N] | ((dvd_reg[N] >= lt) ? 17'd1 : 17'd0);
        ar = (a_reg[N] + AW'(512)) >>> 10;
        if (spec_reg[N])
            th = sth_reg[N];
        else if (ar < 0)
            th = 15'd0;
        else if (ar > AW'(11520))
            th = 15'd11520;
        else
            th = 15'(ar);
        hue_c = sw_reg[N] ? 15'(15'd23040 - th) : th;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v17_reg <= 1'b0;
        else if (adv)
            v17_reg <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rgb17_reg <= rgb_reg[N];
            def17_reg <= def_reg[N];
            hue17_reg <= def_reg[N] ? hue_c : 15'd0;
            sat17_reg <= def_reg[N] ? qf : 17'd0;
            r17_reg   <= r_reg[N];
            sum17_reg <= sum_reg[N];
        end
    end

    // decision: one multiply and compares
    logic [23:0] bound;
    logic [24:0] satx;
    logic        hsi_c;

    always_comb
    begin
        bound = 24'(8'(8'd255 - r17_reg)) * 24'(cfg.saturation_slope);
        satx  = {sat17_reg, 8'd0};
        hsi_c = rgb17_reg && def17_reg
                && (hue17_reg <= 15'(cfg.hue_limit_degrees) * 15'd64)
                && (sum17_reg > cfg.intensity_sum_threshold)
                && (satx >= 25'(bound));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= v17_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pix.rgb_fire      <= rgb17_reg;
            out_pix.hsi_fire      <= hsi_c;
            out_pix.hue_defined   <= def17_reg;
            out_pix.hue           <= hue17_reg;
            out_pix.saturation    <= sat17_reg;
            out_pix.intensity_sum <= sum17_reg;
        end
    end
endmodule

// ===== rtl/fpcc_skid.sv =====
// Output skid buffer decoupling the pipeline from downstream ready.
module fpcc_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fpcc_pkg::pix_out_t in_pix,
    output logic               adv,
    fpcc_stream_if.source      out_ch
);
    logic               hold_valid_reg;
    fpcc_pkg::pix_out_t hold_reg;
    logic               outv_reg;
    fpcc_pkg::pix_out_t outd_reg;

    // pipeline advances while the skid slot is free
    assign adv          = !hold_valid_reg;
    assign out_ch.valid = outv_reg;
    assign out_ch.data  = outd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            outv_reg       <= 1'b0;
        end
        else
        begin
            if (!outv_reg || out_ch.ready)
            begin
                if (hold_valid_reg)
                begin
                    outv_reg       <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end
                else
                    outv_reg <= in_valid;
            end
            else if (in_valid && !hold_valid_reg)
                hold_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!outv_reg || out_ch.ready)
            outd_reg <= hold_valid_reg ? hold_reg : in_pix;
        else if (!hold_valid_reg)
            hold_reg <= in_pix;
    end
endmodule

// ===== rtl/fire_pixel_color_classifier_core.sv =====
// Path: front-end register, CORDIC and divider stages, rounding and decision registers, skid output register.
// Throughput: one pixel per cycle while not stalled; 16-stage CORDIC and divider pipeline.
// Stalls freeze the whole pipeline; a skid slot absorbs one in-flight result.
// Reset: rst_n async active low clears valid bits and loads register defaults.
module fire_pixel_color_classifier_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    fpcc_stream_if.sink  in_ch,
    fpcc_stream_if.source out_ch
);
    fpcc_pkg::cfg_t     cfg_reg;
    fpcc_pkg::pix_out_t pipe_pix;
    logic               pipe_valid, adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_threshold           <= 8'd250;
            cfg_reg.hue_limit_degrees       <= 9'd60;
            cfg_reg.intensity_sum_threshold <= 10'd450;
            cfg_reg.saturation_slope        <= 16'd51061;
        end
        else if (cfg_we)
        begin
            unique case (fpcc_pkg::cfg_index_t'(cfg_index))
                fpcc_pkg::REG_RED_THRESHOLD: cfg_reg.red_threshold <= cfg_data[7:0];
                fpcc_pkg::REG_HUE_LIMIT:     cfg_reg.hue_limit_degrees <= cfg_data[8:0];
                fpcc_pkg::REG_INTENSITY_THR: cfg_reg.intensity_sum_threshold <= cfg_data[9:0];
                fpcc_pkg::REG_SAT_SLOPE:     cfg_reg.saturation_slope <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = adv;

    fpcc_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_ch.valid),
        .in_pix    (fpcc_pkg::pix_in_t'(in_ch.data)),
        .cfg       (cfg_reg),
        .out_valid (pipe_valid),
        .out_pix   (pipe_pix)
    );

    fpcc_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_valid && adv),
        .in_pix   (pipe_pix),
        .adv      (adv),
        .out_ch   (out_ch)
    );
endmodule

// ===== rtl/fpcc_checker.sv =====
// Port-level assertions for the classifier core, bound to the top level.
module fpcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [44:0] out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");
    a_hsi_needs_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_data[43] || out_data[44])
        else $error("hsi fire without rgb fire");
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data[42] |-> out_data[41:27] == 15'd0)
        else $error("undefined hue not zero");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
endmodule

bind fire_pixel_color_classifier_core fpcc_checker u_fpcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

// ===== test/fire_pixel_color_classifier_core_tb.sv =====
// Testbench for the fire pixel color classifier: random and directed pixels, scoreboard check.
module fire_pixel_color_classifier_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    fpcc_stream_if #(.Width($bits(fpcc_pkg::pix_in_t)))  in_ch ();
    fpcc_stream_if #(.Width($bits(fpcc_pkg::pix_out_t))) out_ch ();

    fire_pixel_color_classifier_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    fpcc_pkg::cfg_t     regs;
    fpcc_pkg::pix_in_t  pixel_queue[$];
    fpcc_pkg::pix_out_t class_queue[$];
    int       errors;
    bit       calm;
    bit       long_hold;
    int       send_gap;
    int       recv_gap;
    int       hold_count;

    const longint ATAN_STEP[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint hue_angle(longint x, longint y);
        longint acc;
        longint t;
        longint xs;
        longint ys;
        acc = 0;
        if (y == 0)
            return (x > 0) ? 0 : 11520;
        if (x == 0)
            return 5760;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            acc = 90 * 65536;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                acc += ATAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                acc -= ATAN_STEP[i];
            end
        end
        t = floor_shr(acc + 512, 10);
        if (t < 0)
            t = 0;
        if (t > 11520)
            t = 11520;
        return t;
    endfunction

    function automatic fpcc_pkg::pix_out_t classify(fpcc_pkg::pix_in_t p);
        fpcc_pkg::pix_out_t o;
        longint r;
        longint g;
        longint b;
        longint s;
        longint mn;
        longint th;
        longint hu;
        longint sat;
        bit rgb_ok;
        r = p.pixel_red;
        g = p.pixel_green;
        b = p.pixel_blue;
        s = r + g + b;
        mn = (r < g) ? r : g;
        if (b < mn)
            mn = b;
        rgb_ok = p.moving && r > regs.red_threshold && r >= g && g > b;
        o = '0;
        o.rgb_fire = rgb_ok;
        o.intensity_sum = s[9:0];
        if (!(r == g && g == b))
        begin
            th = hue_angle((2 * r - g - b) * 16384, ((g > b) ? g - b : b - g) * 28378);
            hu = (b <= g) ? th : 23040 - th;
            sat = ((s - 3 * mn) * 65536 + s / 2) / s;
            o.hue_defined = 1'b1;
            o.hue = hu[14:0];
            o.saturation = sat[16:0];
            o.hsi_fire = rgb_ok && hu <= longint'(regs.hue_limit_degrees) * 64
                && s > regs.intensity_sum_threshold
                && sat * 256 >= (255 - r) * longint'(regs.saturation_slope);
        end
        return o;
    endfunction

    function automatic fpcc_pkg::pix_in_t make_pixel(int r, int g, int b, int m);
        fpcc_pkg::pix_in_t p;
        p.pixel_red = r[7:0];
        p.pixel_green = g[7:0];
        p.pixel_blue = b[7:0];
        p.moving = m[0];
        return p;
    endfunction

    function automatic fpcc_pkg::pix_in_t random_pixel();
        int r;
        int g;
        int b;
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(regs.red_threshold, 255);
            g = $urandom_range(0, r);
            b = (g == 0) ? 0 : $urandom_range(0, g - 1);
            return make_pixel(r, g, b, $urandom_range(0, 7) != 0);
        end
        return make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 1));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("fire_pixel_color_classifier_core verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            class_queue.push_back(classify(pixel_queue.pop_front()));
        if (!in_ch.valid || in_ch.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pixel_queue.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pixel_queue[0];
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 8);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            if (class_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, out_ch.data);
            end
            else if (out_ch.data !== class_queue[0])
            begin
                errors++;
                $display("%0t: expected %p actual %p", $time, class_queue[0],
                         fpcc_pkg::pix_out_t'(out_ch.data));
                void'(class_queue.pop_front());
            end
            else
                void'(class_queue.pop_front());
        end
        if (long_hold)
        begin
            out_ch.ready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            recv_gap <= $urandom_range(1, 8) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || class_queue.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
    endtask

    task automatic write_reg(fpcc_pkg::cfg_index_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            fpcc_pkg::REG_RED_THRESHOLD: regs.red_threshold = val[7:0];
            fpcc_pkg::REG_HUE_LIMIT:     regs.hue_limit_degrees = val[8:0];
            fpcc_pkg::REG_INTENSITY_THR: regs.intensity_sum_threshold = val[9:0];
            fpcc_pkg::REG_SAT_SLOPE:     regs.saturation_slope = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            pixel_queue.push_back(random_pixel());
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        calm = 1'b0;
        long_hold = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_count = 0;
        cfg_we = 1'b0;
        cfg_index = fpcc_pkg::REG_RED_THRESHOLD;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        regs = '{red_threshold: 8'd250, hue_limit_degrees: 9'd60,
                 intensity_sum_threshold: 10'd450, saturation_slope: 16'd51061};
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pixel_queue.push_back(make_pixel(0, 0, 0, 1));
        pixel_queue.push_back(make_pixel(255, 255, 255, 1));
        pixel_queue.push_back(make_pixel(128, 128, 128, 0));
        pixel_queue.push_back(make_pixel(255, 200, 10, 1));
        pixel_queue.push_back(make_pixel(255, 200, 10, 0));
        pixel_queue.push_back(make_pixel(255, 255, 0, 1));
        pixel_queue.push_back(make_pixel(255, 0, 0, 1));
        pixel_queue.push_back(make_pixel(251, 250, 249, 1));
        pixel_queue.push_back(make_pixel(255, 0, 255, 1));
        pixel_queue.push_back(make_pixel(0, 255, 0, 0));
        pixel_queue.push_back(make_pixel(0, 0, 255, 1));
        pixel_queue.push_back(make_pixel(0, 255, 255, 1));
        pixel_queue.push_back(make_pixel(100, 50, 200, 1));
        pixel_queue.push_back(make_pixel(255, 254, 0, 1));
        pixel_queue.push_back(make_pixel(250, 100, 50, 1));
        pixel_queue.push_back(make_pixel(1, 0, 0, 1));
        pixel_queue.push_back(make_pixel(0, 1, 0, 0));
        pixel_queue.push_back(make_pixel(170, 85, 85, 1));
        wait_drained();

        write_reg(fpcc_pkg::REG_RED_THRESHOLD, 16'hFF00);
        write_reg(fpcc_pkg::REG_HUE_LIMIT, 16'd0);
        write_reg(fpcc_pkg::REG_INTENSITY_THR, 16'd0);
        write_reg(fpcc_pkg::REG_SAT_SLOPE, 16'd0);
        random_phase(60);

        write_reg(fpcc_pkg::REG_RED_THRESHOLD, 16'd255);
        write_reg(fpcc_pkg::REG_HUE_LIMIT, 16'd511);
        write_reg(fpcc_pkg::REG_INTENSITY_THR, 16'd1023);
        write_reg(fpcc_pkg::REG_SAT_SLOPE, 16'hFFFF);
        random_phase(60);

        write_reg(fpcc_pkg::REG_RED_THRESHOLD, 16'd150);
        write_reg(fpcc_pkg::REG_HUE_LIMIT, 16'd360);
        write_reg(fpcc_pkg::REG_INTENSITY_THR, 16'd765);
        write_reg(fpcc_pkg::REG_SAT_SLOPE, 16'd20000);
        random_phase(80);

        write_reg(fpcc_pkg::REG_RED_THRESHOLD, 16'd180);
        write_reg(fpcc_pkg::REG_HUE_LIMIT, 16'd60);
        write_reg(fpcc_pkg::REG_INTENSITY_THR, 16'd300);
        write_reg(fpcc_pkg::REG_SAT_SLOPE, 16'd51061);
        long_hold = 1'b1;
        for (int i = 0; i < 60; i++)
            pixel_queue.push_back(random_pixel());
        while (hold_count < 100)
            @(posedge clk);
        long_hold = 1'b0;
        wait_drained();

        random_phase(160);
        calm = 1'b1;
        random_phase(80);

        if (errors == 0)
            $display("fire_pixel_color_classifier_core verification clean");
        else
            $display("fire_pixel_color_classifier_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fpcc_pkg.sv
rtl/fpcc_stream_if.sv
rtl/fpcc_pipe.sv
rtl/fpcc_skid.sv
rtl/fire_pixel_color_classifier_core.sv
rtl/fpcc_checker.sv
test/fire_pixel_color_classifier_core_tb.sv
